@@ hdl/dwsfe_pkg.sv @@
// Shared types, constants and arithmetic helpers for the dual wheel speed fault estimator.
`timescale 1ns / 1ps
`default_nettype none
package dwsfe_pkg;

    localparam int CNT_W  = 16;          // encoder count and speed width
    localparam int RAW_W  = CNT_W + 1;   // negated right count needs one more bit
    localparam int ACC_W  = CNT_W + 2;   // raw minus last
    localparam int HALF_W = CNT_W + 2;   // raw plus last
    localparam int NUM_W  = CNT_W + 5;   // nine times raw plus last
    localparam int PROD_W = 2 * NUM_W;
    localparam int TGT_W  = 10;
    localparam int LIM_W  = 10;
    localparam int REV_W  = 11;
    localparam int TRIP_W = 6;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 11;

    // Divide by ten as a multiply by the scaled reciprocal; exact for |x| < 2^22.
    localparam int DIV10_SHIFT = 23;
    localparam logic [NUM_W-1:0] DIV10_MUL = NUM_W'((2 ** DIV10_SHIFT) / 10 + 1);

    typedef enum logic [1:0] {
        FK_NONE  = 2'd0,
        FK_SPIKE = 2'd1,
        FK_OVER  = 2'd2,
        FK_REV   = 2'd3
    } fault_kind_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SPIKE_LIMIT      = 3'd0,
        CFG_OVERSPEED_MARGIN = 3'd1,
        CFG_REVERSE_LIMIT    = 3'd2,
        CFG_LOW_SPEED_LIMIT  = 3'd3,
        CFG_TRIP_COUNT       = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic        [LIM_W-1:0]  spike_limit;
        logic        [LIM_W-1:0]  overspeed_margin;
        logic signed [REV_W-1:0]  reverse_limit;
        logic        [LIM_W-1:0]  low_speed_limit;
        logic        [TRIP_W-1:0] trip_count;
    } cfg_t;

    typedef struct packed {
        logic signed [CNT_W-1:0] left_count;
        logic signed [CNT_W-1:0] right_count;
        logic        [TGT_W-1:0] target_speed;
    } item_t;

    typedef struct packed {
        logic signed [CNT_W-1:0] left_speed;
        logic signed [CNT_W-1:0] right_speed;
        logic signed [CNT_W-1:0] speed_estimate;
        logic        [1:0]       left_fault;
        logic        [1:0]       right_fault;
        logic                    stop_request;
    } result_t;

    // What a wheel lane hands on: its new fault kind and filtered speed.
    typedef struct packed {
        fault_kind_t             kind;
        logic signed [CNT_W-1:0] speed;
    } lane_res_t;

    // Stage one to stage two.
    typedef struct packed {
        logic signed [CNT_W-1:0] left_speed;
        logic signed [CNT_W-1:0] right_speed;
        fault_kind_t             left_kind;
        fault_kind_t             right_kind;
        logic                    count_hit;
        logic        [TGT_W-1:0] target;
    } stage_t;

    // Truncating divide by ten, sign handled on the magnitude.
    function automatic logic signed [CNT_W-1:0] div10(input logic signed [NUM_W-1:0] x);
        logic [NUM_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [NUM_W-1:0]  q;
        mag  = x[NUM_W-1] ? NUM_W'(-x) : NUM_W'(x);
        prod = PROD_W'(mag) * PROD_W'(DIV10_MUL);
        q    = NUM_W'(prod >> DIV10_SHIFT);
        return x[NUM_W-1] ? CNT_W'(-q) : CNT_W'(q);
    endfunction

    // Truncating halve toward zero.
    function automatic logic signed [CNT_W-1:0] half(input logic signed [HALF_W-1:0] s);
        logic signed [HALF_W-1:0] adj;
        adj = s;
        if (s[HALF_W-1]) begin
            adj = s + HALF_W'(1);
        end
        return CNT_W'(adj >>> 1);
    endfunction

    // Nine times a plus b, widened.
    function automatic logic signed [NUM_W-1:0] nine_plus(input logic signed [RAW_W-1:0] a,
                                                          input logic signed [CNT_W-1:0] b);
        return (NUM_W'(a) <<< 3) + NUM_W'(a) + NUM_W'(b);
    endfunction

endpackage
`default_nettype wire

@@ hdl/dwsfe_wheel_lane.sv @@
// One wheel lane: fault classification, speed filter and the wheel's own state.
`timescale 1ns / 1ps
`default_nettype none
module dwsfe_wheel_lane (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   en,
    input  wire logic signed [dwsfe_pkg::RAW_W-1:0] raw,
    input  wire logic [dwsfe_pkg::TGT_W-1:0]      target,
    input  wire dwsfe_pkg::cfg_t                  cfg,
    input  wire                                   kind_clr,
    output dwsfe_pkg::lane_res_t                  res
);
    import dwsfe_pkg::*;

    logic signed [CNT_W-1:0] last_reg;
    fault_kind_t             kind_reg;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] spike_s;
    logic [TGT_W:0]          top_u;
    logic signed [RAW_W-1:0] top_s;
    logic signed [RAW_W-1:0] rev_s;
    logic                    spike_hit;
    fault_kind_t             kind_next;

    assign acc       = ACC_W'(raw) - ACC_W'(last_reg);
    assign spike_s   = $signed(ACC_W'(cfg.spike_limit));
    assign top_u     = (TGT_W + 1)'(target) + (TGT_W + 1)'(cfg.overspeed_margin);
    assign top_s     = $signed(RAW_W'(top_u));
    assign rev_s     = RAW_W'(cfg.reverse_limit);
    assign spike_hit = acc > spike_s;

    // Later checks override earlier ones; release once back in band.
    always_comb begin
        kind_next = kind_reg;
        if (spike_hit) begin
            kind_next = FK_SPIKE;
        end
        if (raw > top_s) begin
            kind_next = FK_OVER;
        end
        if (raw < rev_s) begin
            kind_next = FK_REV;
        end
        if (kind_next != FK_NONE && !spike_hit && raw < top_s && raw > RAW_W'(0)) begin
            kind_next = FK_NONE;
        end
    end

    always_comb begin
        res.kind = kind_next;
        if (kind_next == FK_NONE) begin
            res.speed = div10(nine_plus(raw, last_reg));
        end else begin
            res.speed = half(HALF_W'(raw) + HALF_W'(last_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
            kind_reg <= FK_NONE;
        end else if (en) begin
            last_reg <= res.speed;
            kind_reg <= kind_clr ? FK_NONE : kind_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/dwsfe_merge.sv @@
// Merging stage: fault tick counter and combined speed filter.
`timescale 1ns / 1ps
`default_nettype none
module dwsfe_merge (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                en,
    input  wire dwsfe_pkg::stage_t             stg,
    input  wire logic [dwsfe_pkg::TRIP_W-1:0]  trip_count,
    output logic signed [dwsfe_pkg::CNT_W-1:0] estimate,
    output logic                               stop
);
    import dwsfe_pkg::*;

    logic [TRIP_W-1:0]       ticks_reg;
    logic [TRIP_W-1:0]       ticks_next;
    logic signed [CNT_W-1:0] est_last_reg;
    logic [TRIP_W:0]         ticks_inc;
    logic signed [CNT_W-1:0] tgt_s;
    logic signed [CNT_W-1:0] now;
    logic                    lf;
    logic                    rf;
    logic                    l_hard;
    logic                    r_hard;

    assign ticks_inc = (TRIP_W + 1)'(ticks_reg) + (TRIP_W + 1)'(1);

    always_comb begin
        ticks_next = ticks_reg;
        stop       = 1'b0;
        if (stg.count_hit) begin
            if (ticks_inc >= (TRIP_W + 1)'(trip_count)) begin
                ticks_next = '0;
                stop       = 1'b1;
            end else begin
                ticks_next = TRIP_W'(ticks_inc);
            end
        end
    end

    assign tgt_s  = $signed(CNT_W'(stg.target));
    assign lf     = stg.left_kind != FK_NONE;
    assign rf     = stg.right_kind != FK_NONE;
    assign l_hard = stg.left_kind == FK_SPIKE || stg.left_kind == FK_OVER;
    assign r_hard = stg.right_kind == FK_SPIKE || stg.right_kind == FK_OVER;

    always_comb begin
        priority if (l_hard && r_hard) begin
            now = tgt_s;
        end else if (lf) begin
            now = (stg.right_speed > tgt_s) ? tgt_s : stg.right_speed;
        end else if (rf) begin
            now = (stg.left_speed > tgt_s) ? tgt_s : stg.left_speed;
        end else begin
            now = half(HALF_W'(stg.left_speed) + HALF_W'(stg.right_speed));
        end
    end

    assign estimate = div10(nine_plus(RAW_W'(now), est_last_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg    <= '0;
            est_last_reg <= '0;
        end else if (en) begin
            ticks_reg    <= ticks_next;
            est_last_reg <= estimate;
        end
    end

endmodule
`default_nettype wire

@@ hdl/dual_wheel_speed_fault_estimator_top.sv @@
// Top level of the dual wheel speed fault estimator: config registers, lanes and pipeline.
// An accepted request is registered in stage one, then in the output register; stage one
// holds its request while the output register is stalled.
// Throughput: one request per cycle unless the output stalls; set by the per-wheel filter
// loop, where each wheel's last speed feeds the next request's fault check and filter.
// Reset (aresetn low, synchronous): pipeline empties, wheel and estimate state and
// the fault counter clear, and the config registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module dual_wheel_speed_fault_estimator_top (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // request channel
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire dwsfe_pkg::item_t                s_item,
    // result channel
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output dwsfe_pkg::result_t                   m_result,
    // config write port
    input  wire                                  cfg_we,
    input  wire logic [dwsfe_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [dwsfe_pkg::CFG_DW-1:0]    cfg_wdata
);
    import dwsfe_pkg::*;

    cfg_t      cfg_reg;
    logic      p1_valid_reg;
    stage_t    p1_reg;
    stage_t    p1_next;
    logic      m_valid_reg;
    result_t   m_result_reg;

    logic      advance;
    logic      s_fire;
    logic      p1_fire;
    lane_res_t left_res;
    lane_res_t right_res;
    logic      right_clr;
    logic      lf;
    logic      rf;
    logic signed [CNT_W-1:0] lo_s;
    logic signed [RAW_W-1:0] left_raw;
    logic signed [RAW_W-1:0] right_raw;
    logic signed [CNT_W-1:0] est;
    logic      stop;

    // Config writes: take the low bits of the data; drop unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spike_limit      <= LIM_W'(100);
            cfg_reg.overspeed_margin <= LIM_W'(200);
            cfg_reg.reverse_limit    <= -REV_W'(350);
            cfg_reg.low_speed_limit  <= LIM_W'(20);
            cfg_reg.trip_count       <= TRIP_W'(40);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_SPIKE_LIMIT:      cfg_reg.spike_limit      <= cfg_wdata[LIM_W-1:0];
                CFG_OVERSPEED_MARGIN: cfg_reg.overspeed_margin <= cfg_wdata[LIM_W-1:0];
                CFG_REVERSE_LIMIT:    cfg_reg.reverse_limit    <= $signed(cfg_wdata[REV_W-1:0]);
                CFG_LOW_SPEED_LIMIT:  cfg_reg.low_speed_limit  <= cfg_wdata[LIM_W-1:0];
                CFG_TRIP_COUNT:       cfg_reg.trip_count       <= cfg_wdata[TRIP_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the output register advances when empty or being drained;
    // stage one takes a new request whenever it is empty or moving on.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;
    assign p1_fire = p1_valid_reg && advance;

    // Raw speeds: left as is, right negated (one extra bit for the most negative count).
    assign left_raw  = RAW_W'(s_item.left_count);
    assign right_raw = -RAW_W'(s_item.right_count);

    dwsfe_wheel_lane u_right_lane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (s_fire),
        .raw      (right_raw),
        .target   (s_item.target_speed),
        .cfg      (cfg_reg),
        .kind_clr (right_clr),
        .res      (right_res)
    );

    dwsfe_wheel_lane u_left_lane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (s_fire),
        .raw      (left_raw),
        .target   (s_item.target_speed),
        .cfg      (cfg_reg),
        .kind_clr (1'b0),
        .res      (left_res)
    );

    // Counting condition: both wheels faulted, or one faulted while the other is
    // nearly stopped. Without it the right wheel's fault is dropped; this must land
    // in the lane state this cycle, since the next request's check reads it.
    assign lo_s      = $signed(CNT_W'(cfg_reg.low_speed_limit));
    assign lf        = left_res.kind != FK_NONE;
    assign rf        = right_res.kind != FK_NONE;
    assign p1_next.count_hit = (lf && rf) || (lf && right_res.speed < lo_s)
                               || (rf && left_res.speed < lo_s);
    assign right_clr = !p1_next.count_hit;

    assign p1_next.left_speed  = left_res.speed;
    assign p1_next.right_speed = right_res.speed;
    assign p1_next.left_kind   = left_res.kind;
    assign p1_next.right_kind  = right_clr ? FK_NONE : right_res.kind;
    assign p1_next.target      = s_item.target_speed;

    // Stage one register: hold while stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_reg <= p1_next;
        end
    end

    // Stage two: fault counter and combined estimate, state advanced as the
    // request moves into the output register.
    dwsfe_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (p1_fire),
        .stg        (p1_reg),
        .trip_count (cfg_reg.trip_count),
        .estimate   (est),
        .stop       (stop)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_fire) begin
            m_result_reg.left_speed     <= p1_reg.left_speed;
            m_result_reg.right_speed    <= p1_reg.right_speed;
            m_result_reg.speed_estimate <= est;
            m_result_reg.left_fault     <= p1_reg.left_kind;
            m_result_reg.right_fault    <= p1_reg.right_kind;
            m_result_reg.stop_request   <= stop;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule
`default_nettype wire
